/* design/tno_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tno_pkg: shared types, constants and step functions
// Payload structs, pipeline depths and the square-root and divide steps.
// ============================================================================
package tno_pkg;

    localparam int NORM_BITS = 30;
    localparam int SQ_STAGES = 8;
    localparam int SQ_STEPS  = 4;
    localparam int DV_STAGES = 8;
    localparam int DV_STEPS  = 4;

    localparam logic [1:0] CORNER_A = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_C = 2'd2;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by_coord;
        logic signed [31:0] bz;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [1:0]         corner;
        logic               last;
        logic               degenerate;
    } t_out;

    typedef struct packed {
        logic [2:0][2:0][31:0] pv;
        logic [2:0]            neg;
        logic                  degen;
    } t_carry;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
    } t_sq;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] q;
    } t_dv;

    function automatic t_sq sq_step(input t_sq s, input logic [5:0] pos);
        logic [63:0] bt;
        logic [63:0] trial;
        t_sq         r;
        bt    = 64'd1 << pos;
        trial = s.res + bt;
        r     = s;
        if (s.v >= trial) begin
            r.v   = s.v - trial;
            r.res = (s.res >> 1) + bt;
        end else begin
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    function automatic t_dv dv_step(input t_dv s, input logic [31:0] mag);
        logic [32:0] r33;
        t_dv         r;
        r33 = {s.rem, s.q[31]};
        if (r33 >= {1'b0, mag}) begin
            r.rem = 32'(r33 - {1'b0, mag});
            r.q   = {s.q[30:0], 1'b1};
        end else begin
            r.rem = r33[31:0];
            r.q   = {s.q[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/tno_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tno_front: edge vectors and cross product
// Three stages: differences, six signed products, normal magnitudes and signs.
// ============================================================================
module tno_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire tno_pkg::t_in    i_in,
    output logic                 o_valid,
    output tno_pkg::t_carry      o_carry,
    output logic [2:0][65:0]     o_m
);
    import tno_pkg::*;

    logic                     r_v1, r_v2, r_v3;
    t_carry                   r_c1, r_c2, r_c3, n_c1, n_c3;
    logic signed [32:0]       r_ev [3];
    logic signed [32:0]       r_ew [3];
    logic signed [65:0]       r_pr [6];
    logic [2:0][65:0]         r_m, n_m;

    always_comb begin
        n_c1          = '0;
        n_c1.pv[0][0] = i_in.ax;
        n_c1.pv[0][1] = i_in.ay;
        n_c1.pv[0][2] = i_in.az;
        n_c1.pv[1][0] = i_in.bx;
        n_c1.pv[1][1] = i_in.by_coord;
        n_c1.pv[1][2] = i_in.bz;
        n_c1.pv[2][0] = i_in.cx;
        n_c1.pv[2][1] = i_in.cy;
        n_c1.pv[2][2] = i_in.cz;
    end

    always_comb begin
        logic signed [66:0] nn;
        n_c3 = r_c2;
        n_m  = '0;
        for (int i = 0; i < 3; i++) begin
            nn = 67'(r_pr[2*i]) - 67'(r_pr[2*i+1]);
            n_c3.neg[i] = nn[66];
            n_m[i] = nn[66] ? 66'(-nn) : nn[65:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1     <= n_c1;
            r_ev[0]  <= 33'(i_in.bx) - 33'(i_in.ax);
            r_ev[1]  <= 33'(i_in.by_coord) - 33'(i_in.ay);
            r_ev[2]  <= 33'(i_in.bz) - 33'(i_in.az);
            r_ew[0]  <= 33'(i_in.cx) - 33'(i_in.bx);
            r_ew[1]  <= 33'(i_in.cy) - 33'(i_in.by_coord);
            r_ew[2]  <= 33'(i_in.cz) - 33'(i_in.bz);
            r_c2     <= r_c1;
            r_pr[0]  <= r_ev[1] * r_ew[2];
            r_pr[1]  <= r_ev[2] * r_ew[1];
            r_pr[2]  <= r_ev[2] * r_ew[0];
            r_pr[3]  <= r_ev[0] * r_ew[2];
            r_pr[4]  <= r_ev[0] * r_ew[1];
            r_pr[5]  <= r_ev[1] * r_ew[0];
            r_c3     <= n_c3;
            r_m      <= n_m;
        end
    end

    assign o_valid = r_v3;
    assign o_carry = r_c3;
    assign o_m     = r_m;

endmodule
`default_nettype wire

/* design/tno_norm.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tno_norm: normal scaling and squared length
// Four stages: bit length, scaling shift, squares, sum of squares.
// ============================================================================
module tno_norm (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire tno_pkg::t_carry   i_carry,
    input  wire logic [2:0][65:0]  i_m,
    output logic                   o_valid,
    output tno_pkg::t_carry        o_carry,
    output logic [2:0][29:0]       o_mm,
    output logic [61:0]            o_sum
);
    import tno_pkg::*;

    logic               r_v4, r_v5, r_v6, r_v7;
    t_carry             r_c4, r_c5, r_c6, r_c7, n_c4;
    logic [2:0][65:0]   r_m4;
    logic [6:0]         r_len, n_len;
    logic [2:0][29:0]   r_mm5, r_mm6, r_mm7, n_mm;
    logic [59:0]        r_sq [3];
    logic [61:0]        r_sum;

    always_comb begin
        logic [65:0] orv;
        orv   = i_m[0] | i_m[1] | i_m[2];
        n_len = '0;
        for (int j = 0; j < 66; j++) begin
            if (orv[j]) begin
                n_len = 7'(j + 1);
            end
        end
        n_c4       = i_carry;
        n_c4.degen = (orv == '0);
    end

    always_comb begin
        logic [65:0] sh;
        n_mm = '0;
        for (int i = 0; i < 3; i++) begin
            if (r_len > 7'(NORM_BITS)) begin
                sh = r_m4[i] >> (r_len - 7'(NORM_BITS));
            end else begin
                sh = r_m4[i] << (7'(NORM_BITS) - r_len);
            end
            n_mm[i] = sh[29:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c4  <= n_c4;
            r_m4  <= i_m;
            r_len <= n_len;
            r_c5  <= r_c4;
            r_mm5 <= n_mm;
            r_c6  <= r_c5;
            r_mm6 <= r_mm5;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_mm5[i] * r_mm5[i];
            end
            r_c7  <= r_c6;
            r_mm7 <= r_mm6;
            r_sum <= 62'(r_sq[0]) + 62'(r_sq[1]) + 62'(r_sq[2]);
        end
    end

    assign o_valid = r_v7;
    assign o_carry = r_c7;
    assign o_mm    = r_mm7;
    assign o_sum   = r_sum;

endmodule
`default_nettype wire

/* design/tno_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tno_sqrt: pipelined integer square root
// Restoring square root, a few result bits per stage.
// ============================================================================
module tno_sqrt (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire tno_pkg::t_carry   i_carry,
    input  wire logic [2:0][29:0]  i_mm,
    input  wire logic [61:0]       i_sum,
    output logic                   o_valid,
    output tno_pkg::t_carry        o_carry,
    output logic [2:0][29:0]       o_mm,
    output logic [31:0]            o_mag
);
    import tno_pkg::*;

    logic             r_vld [SQ_STAGES];
    t_carry           r_c   [SQ_STAGES];
    logic [2:0][29:0] r_mm  [SQ_STAGES];
    t_sq              r_st  [SQ_STAGES];
    t_sq              w_in  [SQ_STAGES];
    t_sq              n_st  [SQ_STAGES];

    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign w_in[g] = '{v: {2'b00, i_sum}, res: '0};
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (i_en) begin
                    r_vld[g] <= i_valid;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_c[g]  <= i_carry;
                    r_mm[g] <= i_mm;
                end
            end
        end else begin : g_rest
            assign w_in[g] = r_st[g-1];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (i_en) begin
                    r_vld[g] <= r_vld[g-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_c[g]  <= r_c[g-1];
                    r_mm[g] <= r_mm[g-1];
                end
            end
        end

        always_comb begin
            t_sq t;
            t = w_in[g];
            for (int j = 0; j < SQ_STEPS; j++) begin
                t = sq_step(t, 6'(62 - 2 * (SQ_STEPS * g + j)));
            end
            n_st[g] = t;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g] <= n_st[g];
            end
        end
    end

    assign o_valid = r_vld[SQ_STAGES-1];
    assign o_carry = r_c[SQ_STAGES-1];
    assign o_mm    = r_mm[SQ_STAGES-1];
    assign o_mag   = r_st[SQ_STAGES-1].res[31:0];

endmodule
`default_nettype wire

/* design/tno_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tno_div: pipelined unit normal divide
// Three restoring dividers in lockstep, a few quotient bits per stage.
// ============================================================================
module tno_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire tno_pkg::t_carry   i_carry,
    input  wire logic [2:0][29:0]  i_mm,
    input  wire logic [31:0]       i_mag,
    output logic                   o_valid,
    output tno_pkg::t_carry        o_carry,
    output logic [2:0][31:0]       o_u
);
    import tno_pkg::*;

    logic        r_vld [DV_STAGES];
    t_carry      r_c   [DV_STAGES];
    logic [31:0] r_mag [DV_STAGES];
    t_dv [2:0]   r_st  [DV_STAGES];
    t_dv [2:0]   w_in  [DV_STAGES];
    t_dv [2:0]   n_st  [DV_STAGES];
    logic [31:0] w_mag [DV_STAGES];
    t_dv [2:0]   w_init;

    always_comb begin
        logic [60:0] numer;
        for (int i = 0; i < 3; i++) begin
            numer         = (61'(i_mm[i]) << NORM_BITS) + 61'(i_mag >> 1);
            w_init[i].rem = 32'(numer >> 32);
            w_init[i].q   = numer[31:0];
        end
    end

    for (genvar g = 0; g < DV_STAGES; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign w_in[g]  = w_init;
            assign w_mag[g] = i_mag;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (i_en) begin
                    r_vld[g] <= i_valid;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_c[g] <= i_carry;
                end
            end
        end else begin : g_rest
            assign w_in[g]  = r_st[g-1];
            assign w_mag[g] = r_mag[g-1];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (i_en) begin
                    r_vld[g] <= r_vld[g-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_c[g] <= r_c[g-1];
                end
            end
        end

        always_comb begin
            t_dv t;
            for (int i = 0; i < 3; i++) begin
                t = w_in[g][i];
                for (int j = 0; j < DV_STEPS; j++) begin
                    t = dv_step(t, w_mag[g]);
                end
                n_st[g][i] = t;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g]  <= n_st[g];
                r_mag[g] <= w_mag[g];
            end
        end
    end

    assign o_valid = r_vld[DV_STAGES-1];
    assign o_carry = r_c[DV_STAGES-1];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_u[i] = r_st[DV_STAGES-1][i].q;
        end
    end

endmodule
`default_nettype wire

/* design/tno_out.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tno_out: offset, saturation and result serializer
// Scales the unit normal, adds it to each vertex and sends A, B, C in turn.
// ============================================================================
module tno_out (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire tno_pkg::t_carry   i_carry,
    input  wire logic [2:0][31:0]  i_u,
    input  wire logic [31:0]       i_offset,
    input  wire logic              i_stall,
    output logic                   o_en,
    output logic                   o_valid,
    output tno_pkg::t_out          o_out
);
    import tno_pkg::*;

    localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
    localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

    logic                  r_mv, r_fv, r_ov;
    t_carry                r_mc;
    logic                  r_lneg;
    logic [63:0]           r_prod [3];
    logic [2:0][2:0][31:0] r_f, n_f, r_s;
    logic                  r_fdeg, r_sdeg;
    logic [1:0]            r_cnt;
    logic [31:0]           w_lmag;
    logic                  w_take, w_load, w_can;

    assign w_lmag = i_offset[31] ? (~i_offset + 32'd1) : i_offset;

    always_comb begin
        logic [33:0]        d;
        logic signed [34:0] delta;
        logic signed [34:0] sum;
        n_f = '0;
        for (int i = 0; i < 3; i++) begin
            d = 34'((r_prod[i] + 64'd536870912) >> 30);
            if (r_mc.degen) begin
                delta = '0;
            end else if (r_lneg != r_mc.neg[i]) begin
                delta = -$signed({1'b0, d});
            end else begin
                delta = $signed({1'b0, d});
            end
            for (int k = 0; k < 3; k++) begin
                sum = 35'($signed(r_mc.pv[k][i])) + delta;
                if (sum > SAT_MAX) begin
                    n_f[k][i] = 32'h7FFF_FFFF;
                end else if (sum < SAT_MIN) begin
                    n_f[k][i] = 32'h8000_0000;
                end else begin
                    n_f[k][i] = sum[31:0];
                end
            end
        end
    end

    assign w_take = r_ov && !i_stall;
    assign w_can  = !r_ov || (w_take && r_cnt == CORNER_C);
    assign o_en   = !r_fv || w_can;
    assign w_load = r_fv && w_can;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv  <= 1'b0;
            r_fv  <= 1'b0;
            r_ov  <= 1'b0;
            r_cnt <= CORNER_A;
        end else begin
            if (o_en) begin
                r_mv <= i_valid;
                r_fv <= r_mv;
            end
            if (w_load) begin
                r_ov  <= 1'b1;
                r_cnt <= CORNER_A;
            end else if (w_take) begin
                if (r_cnt == CORNER_C) begin
                    r_ov <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_mc   <= i_carry;
            r_lneg <= i_offset[31];
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= w_lmag * i_u[i];
            end
            r_f    <= n_f;
            r_fdeg <= r_mc.degen;
        end
        if (w_load) begin
            r_s    <= r_f;
            r_sdeg <= r_fdeg;
        end
    end

    assign o_valid          = r_ov;
    assign o_out.out_x      = r_s[r_cnt][0];
    assign o_out.out_y      = r_s[r_cnt][1];
    assign o_out.out_z      = r_s[r_cnt][2];
    assign o_out.corner     = r_cnt;
    assign o_out.last       = (r_cnt == CORNER_C);
    assign o_out.degenerate = r_sdeg;

endmodule
`default_nettype wire

/* design/triangle_normal_offset_top.sv */
// Each request passes through the front, norm, square-root, divide and output registers; A, B and C then leave in turn.
// The single result port sets the rate: the pipeline holds while a finished triangle waits for the port.
// Pipeline: cross product, scaling, 8-stage square root, 8-stage divide, offset.
// Reset: synchronous active low; clears all valid bits and the offset register r_off to 0.
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// triangle_normal_offset_top: push triangle corners along the face normal
// Pipelined unit normal with one offset applied to every vertex, and saturation.
// ============================================================================
module triangle_normal_offset_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [31:0]    i_cfg_wdata,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire tno_pkg::t_in   i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output tno_pkg::t_out       o_out
);
    import tno_pkg::*;

    logic [31:0]      r_off;
    logic             w_en;
    logic             w_fv, w_nv, w_sv, w_dv;
    t_carry           w_fc, w_nc, w_sc, w_dc;
    logic [2:0][65:0] w_m;
    logic [2:0][29:0] w_nmm, w_smm;
    logic [61:0]      w_sum;
    logic [31:0]      w_mag;
    logic [2:0][31:0] w_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= '0;
        end else if (i_cfg_we) begin
            r_off <= i_cfg_wdata;
        end
    end

    assign o_in_stall = !w_en;

    tno_front u_front (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(i_in_valid), .i_in,
        .o_valid(w_fv), .o_carry(w_fc), .o_m(w_m)
    );

    tno_norm u_norm (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_fv), .i_carry(w_fc), .i_m(w_m),
        .o_valid(w_nv), .o_carry(w_nc), .o_mm(w_nmm), .o_sum(w_sum)
    );

    tno_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_nv), .i_carry(w_nc),
        .i_mm(w_nmm), .i_sum(w_sum),
        .o_valid(w_sv), .o_carry(w_sc), .o_mm(w_smm), .o_mag(w_mag)
    );

    tno_div u_div (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_sv), .i_carry(w_sc),
        .i_mm(w_smm), .i_mag(w_mag),
        .o_valid(w_dv), .o_carry(w_dc), .o_u(w_u)
    );

    tno_out u_out (
        .i_clk, .i_rst_n, .i_valid(w_dv), .i_carry(w_dc), .i_u(w_u),
        .i_offset(r_off), .i_stall(i_out_stall),
        .o_en(w_en), .o_valid(o_out_valid), .o_out
    );

endmodule
`default_nettype wire

/* design/tno_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tno_checker: port-level checks on the result channel
// Corner sequencing, last marking, a stable stalled result and a steady degenerate flag per triangle.
// ============================================================================
module tno_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire tno_pkg::t_out o_out
);
    import tno_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.corner != 2'd3 && o_out.last == (o_out.corner == CORNER_C)))
        else $error("bad corner or last");

    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out.last) |=>
        (o_out_valid && o_out.corner == $past(o_out.corner) + 2'd1))
        else $error("corner sequence broken");

    a_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out.last) |=>
        (o_out.degenerate == $past(o_out.degenerate)))
        else $error("degenerate flag changed within a triangle");

endmodule

bind triangle_normal_offset_top tno_checker u_tno_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_out(o_out)
);
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb: triangle normal offset regression
// Feeds triangles through the valid/stall port, predicts the three shifted
// corners of each in fixed point and checks every result in order.
// ============================================================================
module tb;
    import tno_pkg::*;

    localparam int LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out;

    t_in         pending_tris[$];
    t_out        corner_results[$];
    logic [31:0] offset_shadow = '0;
    int          fails = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          results_seen = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;

    triangle_normal_offset_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] sat32(longint x);
        if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    function automatic void add_tri(t_in t);
        pending_tris = {pending_tris, t};
    endfunction

    function automatic void add_result(t_out r);
        corner_results = {corner_results, r};
    endfunction

    function automatic void predict_corners(t_in t, logic [31:0] ofs);
        longint                p[3][3];
        logic signed [69:0]    vv[3];
        logic signed [69:0]    ww[3];
        logic signed [69:0]    n[3];
        logic [69:0]           m[3];
        logic [69:0]           orv;
        bit                    ng[3];
        bit                    degen;
        int                    len;
        longint unsigned       mm[3];
        longint unsigned       sum;
        longint unsigned       mag;
        longint unsigned       cand;
        longint unsigned       u;
        longint unsigned       d;
        longint unsigned       lmag;
        longint                o;
        longint                dl[3];
        t_out                  r;
        p[0][0] = t.ax; p[0][1] = t.ay;       p[0][2] = t.az;
        p[1][0] = t.bx; p[1][1] = t.by_coord; p[1][2] = t.bz;
        p[2][0] = t.cx; p[2][1] = t.cy;       p[2][2] = t.cz;
        for (int i = 0; i < 3; i++) begin
            vv[i] = p[1][i] - p[0][i];
            ww[i] = p[2][i] - p[1][i];
            dl[i] = 0;
        end
        n[0] = vv[1] * ww[2] - vv[2] * ww[1];
        n[1] = vv[2] * ww[0] - vv[0] * ww[2];
        n[2] = vv[0] * ww[1] - vv[1] * ww[0];
        orv = '0;
        for (int i = 0; i < 3; i++) begin
            ng[i] = n[i] < 0;
            m[i] = ng[i] ? -n[i] : n[i];
            orv |= m[i];
        end
        len = 0;
        for (int b = 0; b < 70; b++) if (orv[b]) len = b + 1;
        degen = (len == 0);
        if (!degen) begin
            o = $signed(ofs);
            lmag = o < 0 ? -o : o;
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                if (len > NORM_BITS) mm[i] = 64'(m[i] >> (len - NORM_BITS));
                else mm[i] = 64'(m[i]) << (NORM_BITS - len);
                sum += mm[i] * mm[i];
            end
            mag = 0;
            for (int b = 31; b >= 0; b--) begin
                cand = mag | (64'd1 << b);
                if (cand * cand <= sum) mag = cand;
            end
            for (int i = 0; i < 3; i++) begin
                u = ((mm[i] << 30) + (mag >> 1)) / mag;
                d = (lmag * u + (64'd1 << 29)) >> 30;
                dl[i] = ((o < 0) != ng[i]) ? -longint'(d) : longint'(d);
            end
        end
        for (int k = 0; k < 3; k++) begin
            r.out_x = sat32(p[k][0] + dl[0]);
            r.out_y = sat32(p[k][1] + dl[1]);
            r.out_z = sat32(p[k][2] + dl[2]);
            r.corner = (k == 0) ? CORNER_A : (k == 1) ? CORNER_B : CORNER_C;
            r.last = (k == 2);
            r.degenerate = degen;
            add_result(r);
        end
    endfunction

    function automatic t_in tri_of(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                                   logic [31:0] b0, logic [31:0] b1, logic [31:0] b2,
                                   logic [31:0] c0, logic [31:0] c1, logic [31:0] c2);
        t_in t;
        t = {a0, a1, a2, b0, b1, b2, c0, c1, c2};
        return t;
    endfunction

    function automatic logic [31:0] pick_edge();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'($urandom_range(0, 255)) - 32'd128;
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic t_in random_tri();
        logic [31:0] a[3];
        logic [31:0] e1[3];
        logic [31:0] e2[3];
        int          sel;
        t_in         t;
        sel = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            a[i]  = 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
            e1[i] = 32'($urandom_range(0, 32'h1_FFFF)) - 32'h1_0000;
            e2[i] = 32'($urandom_range(0, 32'h1_FFFF)) - 32'h1_0000;
        end
        case (sel)
            5, 6: t = {$urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom};
            7: t = tri_of(a[0], a[1], a[2],
                          a[0] + e1[0], a[1] + e1[1], a[2] + e1[2],
                          a[0] + 2 * e1[0], a[1] + 2 * e1[1], a[2] + 2 * e1[2]);
            8: t = tri_of(pick_edge(), pick_edge(), pick_edge(), pick_edge(),
                          pick_edge(), pick_edge(), pick_edge(), pick_edge(),
                          pick_edge());
            9: t = tri_of(a[0], a[1], a[2],
                          a[0] + (e1[0] >>> 12), a[1] + 3, a[2],
                          a[0], a[1] + (e2[1] >>> 14), a[2] + 1);
            default: t = tri_of(a[0], a[1], a[2],
                                a[0] + e1[0], a[1] + e1[1], a[2] + e1[2],
                                a[0] + e2[0], a[1] + e2[1], a[2] + e2[2]);
        endcase
        return t;
    endfunction

    task automatic queue_directed();
        add_tri(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_tri(tri_of(0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000, 0));
        add_tri(tri_of(0, 0, 0, 0, 32'h1_0000, 0, 32'h1_0000, 0, 0));
        add_tri(tri_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        add_tri(tri_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        add_tri(tri_of(5, 6, 7, 5, 6, 7, 5, 6, 7));
        add_tri(tri_of(0, 0, 0, 1, 2, 3, 2, 4, 6));
        add_tri(tri_of(0, 0, 32'h7FFF_0000, 1, 0, 32'h7FFF_0000,
                       0, 1, 32'h7FFF_0000));
        add_tri(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0));
        add_tri(tri_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0,
                       32'h1));
    endtask

    task automatic drain_and_settle();
        wait (pending_tris.size() == 0 && !i_in_valid && corner_results.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_offset(logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        offset_shadow <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // driver: accept, predict, then offer the next request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) predict_corners(i_in, offset_shadow);
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_tris.size() > 0) begin
                    i_in       <= pending_tris.pop_front();
                    i_in_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 7);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold, once, after 60 results have been seen
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= 60) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
    end

    // monitor: check accepted results, then choose the next stall
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (corner_results.size() == 0) begin
                $error("unexpected result %p", o_out);
                fails++;
            end else begin
                want = corner_results.pop_front();
                if (o_out.out_x !== want.out_x) begin
                    $error("out_x expected %h actual %h", want.out_x, o_out.out_x);
                    fails++;
                end
                if (o_out.out_y !== want.out_y) begin
                    $error("out_y expected %h actual %h", want.out_y, o_out.out_y);
                    fails++;
                end
                if (o_out.out_z !== want.out_z) begin
                    $error("out_z expected %h actual %h", want.out_z, o_out.out_z);
                    fails++;
                end
                if (o_out.corner !== want.corner) begin
                    $error("corner expected %0d actual %0d", want.corner, o_out.corner);
                    fails++;
                end
                if (o_out.last !== want.last) begin
                    $error("last expected %0b actual %0b", want.last, o_out.last);
                    fails++;
                end
                if (o_out.degenerate !== want.degenerate) begin
                    $error("degenerate expected %0b actual %0b",
                           want.degenerate, o_out.degenerate);
                    fails++;
                end
            end
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [31:0] offsets[6];
        offsets = '{32'h0, 32'h1_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'($urandom), 32'hFFFF_0000};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) write_offset(offsets[ph]);
            if (ph == 5) quiet = 1'b1;
            if (ph == 0 || ph == 2 || ph == 3) queue_directed();
            for (int j = 0; j < 72; j++) add_tri(random_tri());
            drain_and_settle();
        end
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

/* triangle_normal_offset_top.f */
design/tno_pkg.sv
design/tno_front.sv
design/tno_norm.sv
design/tno_sqrt.sv
design/tno_div.sv
design/tno_out.sv
design/triangle_normal_offset_top.sv
design/tno_checker.sv
tb/tb.sv
